>>> sv/b2r_pkg.sv
`timescale 1ns / 1ps
// Shared types, letter codes and digit-pattern functions for the Roman numeral converter.
package b2r_pkg;

    // ASCII codes of the numeral letters
    localparam logic [6:0] CH_I = 7'h49;
    localparam logic [6:0] CH_V = 7'h56;
    localparam logic [6:0] CH_X = 7'h58;
    localparam logic [6:0] CH_L = 7'h4C;
    localparam logic [6:0] CH_C = 7'h43;
    localparam logic [6:0] CH_D = 7'h44;
    localparam logic [6:0] CH_M = 7'h4D;
    localparam logic [6:0] CH_NONE = 7'h00;

    localparam logic [11:0] MAX_VALUE = 12'd3999;

    // Decade index: 0 units, 1 tens, 2 hundreds, 3 thousands
    localparam int NUM_DECADES = 4;

    // One decoded input: range flag and four decimal digits
    typedef struct packed {
        logic             err;
        logic [3:0][3:0]  dig;
    } item_t;

    // One result character
    typedef struct packed {
        logic [6:0] symbol;
        logic       last;
        logic       range_error;
    } char_t;

    // Number of letters that one decimal digit expands to
    function automatic logic [2:0] digit_len(input logic [3:0] d);
        logic [2:0] n;
        case (d)
            4'd0:    n = 3'd0;
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Letter at position pos of digit d in decade dec
    function automatic logic [6:0] digit_symbol(input logic [3:0] d,
                                                input logic [1:0] dec,
                                                input logic [1:0] pos);
        logic [6:0] one;
        logic [6:0] five;
        logic [6:0] ten;
        logic [6:0] s;
        case (dec)
            2'd0:    begin one = CH_I; five = CH_V;    ten = CH_X;    end
            2'd1:    begin one = CH_X; five = CH_L;    ten = CH_C;    end
            2'd2:    begin one = CH_C; five = CH_D;    ten = CH_M;    end
            default: begin one = CH_M; five = CH_NONE; ten = CH_NONE; end
        endcase
        if (d == 4'd9)
            s = (pos == 2'd0) ? one : ten;
        else if (d == 4'd4)
            s = (pos == 2'd0) ? one : five;
        else if (d >= 4'd5)
            s = (pos == 2'd0) ? five : one;
        else
            s = one;
        return s;
    endfunction

endpackage

>>> sv/binary_to_roman_numeral_core.sv
`timescale 1ns / 1ps
// A value passes through three digit stages, the queue and the emitter on its way to the output.
// Throughput: one character per cycle from the single-letter emitter while the output has room;
// an item gives one character per letter (1 for an out-of-range value, up to 15 for 3888).
// The front end takes a new value every cycle unless its last stage waits on a full queue.
// Reset (rst_n, asynchronous, active low) empties the pipeline, the queue and the output register.
module binary_to_roman_numeral_core
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [11:0] value,
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  symbol,
    output logic        last,
    output logic        range_error
);

    logic            item_valid;
    b2r_pkg::item_t  item;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    b2r_pkg::item_t  q_data;
    b2r_pkg::char_t  out_char;

    // Accept values and split them into digits
    b2r_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .value      (value),
        .item_valid (item_valid),
        .item       (item),
        .q_full     (q_full)
    );

    // Buffer decoded items
    b2r_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (item_valid),
        .wr_data (item),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    // Emit the numeral letters
    b2r_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_char (out_char)
    );

    assign symbol      = out_char.symbol;
    assign last        = out_char.last;
    assign range_error = out_char.range_error;

endmodule

>>> sv/b2r_front.sv
`timescale 1ns / 1ps
// Front end: accepts values, checks range and splits them into decimal digits over three stages.
module b2r_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [11:0]     value,
    output logic            item_valid,
    output b2r_pkg::item_t  item,
    input  logic            q_full
);

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic        s1_err_reg, s2_err_reg;
    logic [1:0]  s1_th_reg, s2_th_reg;
    logic [9:0]  s1_rem_reg;
    logic [3:0]  s2_hu_reg;
    logic [6:0]  s2_rem_reg;
    b2r_pkg::item_t s3_item_reg;

    logic        adv;
    logic        err_next;
    logic [1:0]  th_next;
    logic [11:0] th_sub;
    logic [9:0]  rem1_next;
    logic [3:0]  hu_next;
    logic [9:0]  hu_sub;
    logic [6:0]  rem2_next;
    logic [3:0]  te_next;
    logic [6:0]  te_sub;
    logic [3:0]  un_next;

    // Advance the whole pipe unless the last stage is stuck on a full queue
    assign adv        = !(s3_valid_reg && q_full);
    assign full       = !adv;
    assign item_valid = s3_valid_reg;
    assign item       = s3_item_reg;

    // Stage 1: range check and thousands digit
    always_comb
    begin
        err_next = (value == 12'd0) || (value > b2r_pkg::MAX_VALUE);
        if (value >= 12'd3000)
            th_next = 2'd3;
        else if (value >= 12'd2000)
            th_next = 2'd2;
        else if (value >= 12'd1000)
            th_next = 2'd1;
        else
            th_next = 2'd0;
        case (th_next)
            2'd0:    th_sub = 12'd0;
            2'd1:    th_sub = 12'd1000;
            2'd2:    th_sub = 12'd2000;
            default: th_sub = 12'd3000;
        endcase
        rem1_next = 10'(value - th_sub);
    end

    // Stage 2: hundreds digit
    always_comb
    begin
        hu_next = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (s1_rem_reg >= 10'(k * 100))
                hu_next = 4'(k);
        end
        hu_sub    = 10'(hu_next) * 10'd100;
        rem2_next = 7'(s1_rem_reg - hu_sub);
    end

    // Stage 3: tens and units digits
    always_comb
    begin
        te_next = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (s2_rem_reg >= 7'(k * 10))
                te_next = 4'(k);
        end
        te_sub  = 7'(te_next) * 7'd10;
        un_next = 4'(s2_rem_reg - te_sub);
    end

    // Hold valid bits under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= push;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Advance payload through the stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_err_reg         <= err_next;
            s1_th_reg          <= th_next;
            s1_rem_reg         <= rem1_next;
            s2_err_reg         <= s1_err_reg;
            s2_th_reg          <= s1_th_reg;
            s2_hu_reg          <= hu_next;
            s2_rem_reg         <= rem2_next;
            s3_item_reg.err    <= s2_err_reg;
            s3_item_reg.dig[3] <= {2'b00, s2_th_reg};
            s3_item_reg.dig[2] <= s2_hu_reg;
            s3_item_reg.dig[1] <= te_next;
            s3_item_reg.dig[0] <= un_next;
        end
    end

endmodule

>>> sv/b2r_fifo.sv
`timescale 1ns / 1ps
// Small register queue that decouples the front end from the character emitter.
module b2r_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  b2r_pkg::item_t  wr_data,
    input  logic            rd_en,
    output b2r_pkg::item_t  rd_data,
    output logic            q_empty,
    output logic            q_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b2r_pkg::item_t   mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr, do_rd;

    assign q_empty = (count_reg == CW'(0));
    assign q_full  = (count_reg == CW'(DEPTH));
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store the incoming transfer
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> sv/b2r_back.sv
`timescale 1ns / 1ps
// Back end: walks an item's digits, one letter per cycle while output has room.
module b2r_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  b2r_pkg::item_t  q_data,
    output logic            q_pop,
    output logic            empty,
    input  logic            pop,
    output b2r_pkg::char_t  out_char
);

    logic            busy_reg;
    b2r_pkg::item_t  item_reg;
    logic [1:0]      dec_reg;
    logic [1:0]      pos_reg;
    logic            out_valid_reg;
    b2r_pkg::char_t  out_reg;

    logic [3:0]      cur_dig;
    logic [2:0]      cur_len;
    logic            end_of_digit;
    logic [2:0]      lower;
    logic [2:0]      first;
    logic            is_last;
    logic            out_room;
    logic            emit;
    b2r_pkg::char_t  char_next;

    // Find the highest nonzero decade below lim; bit 2 flags a hit
    function automatic logic [2:0] hi_nz(input logic [3:0][3:0] dig,
                                         input logic [2:0] lim);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 0; i < b2r_pkg::NUM_DECADES; i++)
        begin
            if ((dig[i] != 4'd0) && (3'(i) < lim))
                r = {1'b1, 2'(i)};
        end
        return r;
    endfunction

    assign cur_dig      = item_reg.dig[dec_reg];
    assign cur_len      = b2r_pkg::digit_len(cur_dig);
    assign end_of_digit = ({1'b0, pos_reg} == (cur_len - 3'd1));
    assign lower        = hi_nz(item_reg.dig, {1'b0, dec_reg});
    assign first        = hi_nz(q_data.dig, 3'd4);
    assign is_last      = item_reg.err || (end_of_digit && !lower[2]);

    assign out_room = !out_valid_reg || pop;
    assign emit     = busy_reg && out_room;
    assign q_pop    = !q_empty && (!busy_reg || (emit && is_last));

    assign empty    = !out_valid_reg;
    assign out_char = out_reg;

    // Form the next character
    always_comb
    begin
        char_next.last        = is_last;
        char_next.range_error = item_reg.err;
        if (item_reg.err)
            char_next.symbol = b2r_pkg::CH_NONE;
        else
            char_next.symbol = b2r_pkg::digit_symbol(cur_dig, dec_reg, pos_reg);
    end

    // Sequence through decades and letter positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            dec_reg       <= 2'd0;
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                dec_reg  <= first[1:0];
                pos_reg  <= 2'd0;
            end
            else if (emit)
            begin
                if (is_last)
                    busy_reg <= 1'b0;
                else if (end_of_digit)
                begin
                    dec_reg <= lower[1:0];
                    pos_reg <= 2'd0;
                end
                else
                    pos_reg <= pos_reg + 2'd1;
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // Load the item and the output character
    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_data;
        if (emit)
            out_reg <= char_next;
    end

endmodule

>>> bench/tb_binary_to_roman_numeral_core.sv
`timescale 1ns / 1ps
// Testbench for the Roman numeral converter: random queue handshakes, predicted letter stream.
module tb_binary_to_roman_numeral_core;

    localparam int DRAIN_MARK = -1;
    localparam int RANDOM_ITEMS = 135;

    // Letters per decade, index 0 units up to 3 thousands
    localparam logic [3:0][6:0] ONE_LETTER  = {b2r_pkg::CH_M, b2r_pkg::CH_C,
                                               b2r_pkg::CH_X, b2r_pkg::CH_I};
    localparam logic [3:0][6:0] FIVE_LETTER = {b2r_pkg::CH_NONE, b2r_pkg::CH_D,
                                               b2r_pkg::CH_L, b2r_pkg::CH_V};
    localparam logic [3:0][6:0] TEN_LETTER  = {b2r_pkg::CH_NONE, b2r_pkg::CH_M,
                                               b2r_pkg::CH_C, b2r_pkg::CH_X};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [11:0] value = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [6:0]  symbol;
    logic        last;
    logic        range_error;

    int             pending_values [$];
    b2r_pkg::char_t numeral_queue [$];
    b2r_pkg::char_t expected_char;
    int             error_count = 0;
    int             char_count = 0;
    int             send_gap = 0;
    int             send_calm = 0;
    int             take_gap = 0;
    int             take_calm = 0;

    binary_to_roman_numeral_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .value       (value),
        .empty       (empty),
        .pop         (pop),
        .symbol      (symbol),
        .last        (last),
        .range_error (range_error)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(3, 1);
        else if (roll < 97)
            return $urandom_range(10, 4);
        else
            return $urandom_range(30, 15);
    endfunction

    // Expand one value into its expected letters, last letter marked
    task automatic expand_numeral(input logic [11:0] v);
        logic [6:0]     letters [$];
        b2r_pkg::char_t c;
        int             rest;
        int             scale;
        int             digit;
        int             dec;
        int             i;
        if (v == 12'd0 || v > b2r_pkg::MAX_VALUE)
        begin
            c.symbol = b2r_pkg::CH_NONE;
            c.last = 1'b1;
            c.range_error = 1'b1;
            numeral_queue = {numeral_queue, c};
            return;
        end
        rest = v;
        scale = 1000;
        for (dec = 3; dec >= 0; dec--)
        begin
            digit = rest / scale;
            rest = rest % scale;
            scale = scale / 10;
            if (digit == 9)
            begin
                letters = {letters, ONE_LETTER[dec]};
                letters = {letters, TEN_LETTER[dec]};
            end
            else if (digit == 4)
            begin
                letters = {letters, ONE_LETTER[dec]};
                letters = {letters, FIVE_LETTER[dec]};
            end
            else
            begin
                if (digit >= 5)
                begin
                    letters = {letters, FIVE_LETTER[dec]};
                    digit = digit - 5;
                end
                for (i = 0; i < digit; i++)
                    letters = {letters, ONE_LETTER[dec]};
            end
        end
        for (i = 0; i < letters.size(); i++)
        begin
            c.symbol = letters[i];
            c.last = (i == letters.size() - 1);
            c.range_error = 1'b0;
            numeral_queue = {numeral_queue, c};
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("MISMATCH %s: got %0d, expected %0d (char %0d)", what, got, want, char_count);
    endtask

    // Sender: hold an item until its transfer, then gap or advance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            value <= '0;
        end
        else if (!(push && full))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (pending_values.size() == 0)
            begin
                push <= 1'b0;
            end
            else if (pending_values[0] == DRAIN_MARK)
            begin
                // Pause until every predicted letter has been taken
                push <= 1'b0;
                if (!push && numeral_queue.size() == 0)
                    void'(pending_values.pop_front());
            end
            else
            begin
                push <= 1'b1;
                value <= 12'(pending_values.pop_front());
                if (send_calm > 0)
                begin
                    send_calm--;
                    send_gap = 0;
                end
                else
                begin
                    send_gap = pick_gap();
                    if ($urandom_range(19) == 0)
                        send_calm = $urandom_range(60, 20);
                end
            end
        end
    end

    // Receiver: predict accepted items, check each transfer, drive pop
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (push && !full)
                expand_numeral(value);
            if (pop && !empty)
            begin
                char_count++;
                if (numeral_queue.size() == 0)
                begin
                    report_mismatch("unexpected letter", symbol, -1);
                end
                else
                begin
                    expected_char = numeral_queue.pop_front();
                    if (symbol !== expected_char.symbol)
                        report_mismatch("symbol", symbol, expected_char.symbol);
                    if (last !== expected_char.last)
                        report_mismatch("last", last, expected_char.last);
                    if (range_error !== expected_char.range_error)
                        report_mismatch("range_error", range_error, expected_char.range_error);
                end
                if (take_calm > 0)
                begin
                    take_calm--;
                    take_gap = 0;
                end
                else
                begin
                    take_gap = pick_gap();
                    if ($urandom_range(19) == 0)
                        take_calm = $urandom_range(60, 20);
                end
            end
            if (take_gap > 0)
            begin
                take_gap--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int directed [$];
        int n;
        int roll;
        int v;
        directed = '{1, 3, 4, 5, 8, 9, 14, 40, 49, 90, 400, 444, 900, 999, 1000, 1994,
                     3000, 3888, 3999, 0, 4000, 4095, 2048, 2730, 1365};
        foreach (directed[i])
            pending_values = {pending_values, directed[i]};
        pending_values = {pending_values, DRAIN_MARK};

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                // Out of range, zero now and then
                v = ($urandom_range(4) == 0) ? 0 : $urandom_range(4095, 4000);
            end
            else if (roll < 18)
            begin
                // Long numerals built from 3, 7 and 8 digits
                v = 3000;
                repeat (3)
                begin
                    roll = $urandom_range(2);
                    v = v / 1000 * 1000 + (v % 1000) * 10
                        + ((roll == 0) ? 3 : (roll == 1) ? 7 : 8);
                end
                v = 3000 + v % 1000;
            end
            else if (roll < 30)
            begin
                v = $urandom_range(4095, 0);
            end
            else
            begin
                v = 1000 * $urandom_range(3) + 100 * $urandom_range(9)
                    + 10 * $urandom_range(9) + $urandom_range(9);
                if (v == 0)
                    v = 1;
            end
            pending_values = {pending_values, v};
            if (n % 40 == 39)
                pending_values = {pending_values, DRAIN_MARK};
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_values.size() != 0 || push || numeral_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (numeral_queue.size() != 0)
            report_mismatch("letters never delivered", 0, numeral_queue.size());
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
